// ===== design/ray_sphere_intersection_unit_macros.svh =====
// Assertion macros for the ray/sphere unit checker.
// Expects signals named clk and rst where a macro is used.
`ifndef RAY_SPHERE_INTERSECTION_UNIT_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is held
`define RSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray/sphere unit check failed");

// Next-cycle implication, quiet while reset is held
`define RSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray/sphere unit check failed");

// Same-cycle implication that also covers reset itself
`define RSI_ASSERT_RAW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("ray/sphere unit check failed");

`endif

// ===== design/rsi_pkg.sv =====
`timescale 1ns / 1ps
// rsi_pkg: widths, beat types and the front-to-back link type of the
// ray/sphere unit. No dependencies.
package rsi_pkg;

  // Coordinate format
  localparam int CW = 32;             // coordinate width
  localparam int FB = 16;             // fraction bits
  localparam int RW = CW - 1;         // radius / distance width

  // Intermediate widths
  localparam int LW  = CW + 1;        // L = origin - centre
  localparam int AW  = 2 * CW;        // a = D.D, unsigned
  localparam int BW  = 2 * CW + 2;    // half b = D.L, signed
  localparam int CCW = 2 * CW + 3;    // c = L.L - r^2, signed
  localparam int DW  = 2 * BW;        // quarter discriminant, when non-negative
  localparam int SW  = BW + FB + 1;   // scaled square root
  localparam int XW  = 2 * SW;        // square root operand
  localparam int NW  = SW + 1;        // numerator, non-negative
  localparam int QW  = NW - 1;        // quotient t
  localparam int PW  = CW + QW + 1;   // dir * t

  // Partial product chunking
  localparam int KB = (BW + 2) / 3;   // |b| in three chunks
  localparam int KA = AW / 2;         // a in two chunks
  localparam int KC = (CCW + 1) / 3;  // |c| in three chunks
  localparam int KT = (QW + 2) / 3;   // t in three chunks

  typedef logic [2:0][CW-1:0] vec3_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic        [RW-1:0] sphere_radius;
  } item_t;

  typedef struct packed {
    logic                 hit;
    logic        [RW-1:0] distance;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } result_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    vec3_t         org;
    vec3_t         dir;
    logic [AW-1:0] a;
    logic [BW-1:0] bh;
    logic [DW-1:0] disc;
    logic          miss;
    logic          use_low;
  } link_t;

endpackage

// ===== design/rsi_front.sv =====
`timescale 1ns / 1ps
// rsi_front: eight-stage pipeline forming a, b/2, c and the quarter
// discriminant, and classifying each ray as miss or hit. Uses rsi_pkg.
module rsi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  rsi_pkg::item_t  item,
  output logic            lq_push,
  input  logic            lq_full,
  output rsi_pkg::link_t  lq_data
);
  import rsi_pkg::*;

  localparam int ACW = 2 * KA + 3 * KC;

  typedef struct packed {
    vec3_t                org;
    vec3_t                dir;
    logic [2:0][LW-1:0]   l;
    logic [RW-1:0]        r;
  } s1_t;

  typedef struct packed {
    vec3_t                org;
    vec3_t                dir;
    logic [2:0][AW-1:0]   dd;
    logic [2:0][AW:0]     dl;
    logic [2:0][AW:0]     ll;
    logic [2*RW-1:0]      rr;
  } s2_t;

  typedef struct packed {
    vec3_t                org;
    vec3_t                dir;
    logic [AW-1:0]        a;
    logic [BW-1:0]        bh;
    logic [CCW-1:0]       c;
  } s3_t;

  typedef struct packed {
    vec3_t                org;
    vec3_t                dir;
    logic [AW-1:0]        a;
    logic [BW-1:0]        bh;
    logic [3*KB-1:0]      bmag;
    logic [3*KC-1:0]      cmag;
    logic                 c_neg;
    logic                 c_zero;
    logic                 b_pos;
  } s4_t;

  typedef struct packed {
    vec3_t                     org;
    vec3_t                     dir;
    logic [AW-1:0]             a;
    logic [BW-1:0]             bh;
    logic                      c_neg;
    logic                      c_zero;
    logic                      b_pos;
    logic [2:0][2:0][2*KB-1:0] pb;
    logic [1:0][2:0][KA+KC-1:0] pac;
  } s5_t;

  typedef struct packed {
    vec3_t                     org;
    vec3_t                     dir;
    logic [AW-1:0]             a;
    logic [BW-1:0]             bh;
    logic                      c_neg;
    logic                      c_zero;
    logic                      b_pos;
    logic [2:0][4*KB-1:0]      rb;
    logic [1:0][KA+3*KC-1:0]   rac;
  } s6_t;

  typedef struct packed {
    vec3_t                org;
    vec3_t                dir;
    logic [AW-1:0]        a;
    logic [BW-1:0]        bh;
    logic                 c_neg;
    logic                 c_zero;
    logic                 b_pos;
    logic [DW-1:0]        bb;
    logic [ACW-1:0]       ac;
  } s7_t;

  s1_t   s1, s1_next;
  s2_t   s2, s2_next;
  s3_t   s3, s3_next;
  s4_t   s4, s4_next;
  s5_t   s5, s5_next;
  s6_t   s6, s6_next;
  s7_t   s7, s7_next;
  link_t s8, s8_next;
  logic  [8:1] v;
  logic  adv;
  logic  [DW:0] dsum;

  // Whole front moves together; it holds only when the link queue backs up
  assign adv     = !(v[8] && lq_full);
  assign full    = !adv;
  assign lq_push = v[8] && !lq_full;
  assign lq_data = s8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[7:1], push};
    end
  end

  // Stage 1: L = origin - centre
  always_comb begin
    s1_next.org = {item.origin_z, item.origin_y, item.origin_x};
    s1_next.dir = {item.dir_z, item.dir_y, item.dir_x};
    s1_next.r   = item.sphere_radius;
    s1_next.l[0] = LW'(item.origin_x) - LW'(item.center_x);
    s1_next.l[1] = LW'(item.origin_y) - LW'(item.center_y);
    s1_next.l[2] = LW'(item.origin_z) - LW'(item.center_z);
  end

  // Stage 2: per-axis products
  always_comb begin
    s2_next.org = s1.org;
    s2_next.dir = s1.dir;
    for (int k = 0; k < 3; k++) begin
      s2_next.dd[k] = AW'($signed(s1.dir[k]) * $signed(s1.dir[k]));
      s2_next.dl[k] = (AW+1)'($signed(s1.dir[k]) * $signed(s1.l[k]));
      s2_next.ll[k] = (AW+1)'($signed(s1.l[k]) * $signed(s1.l[k]));
    end
    s2_next.rr = (2*RW)'(s1.r * s1.r);
  end

  // Stage 3: dot products
  always_comb begin
    s3_next.org = s2.org;
    s3_next.dir = s2.dir;
    s3_next.a   = s2.dd[0] + s2.dd[1] + s2.dd[2];
    s3_next.bh  = BW'($signed(s2.dl[0])) + BW'($signed(s2.dl[1]))
                + BW'($signed(s2.dl[2]));
    s3_next.c   = CCW'(s2.ll[0]) + CCW'(s2.ll[1]) + CCW'(s2.ll[2]) - CCW'(s2.rr);
  end

  // Stage 4: magnitudes and signs
  always_comb begin
    s4_next.org    = s3.org;
    s4_next.dir    = s3.dir;
    s4_next.a      = s3.a;
    s4_next.bh     = s3.bh;
    s4_next.c_neg  = s3.c[CCW-1];
    s4_next.c_zero = (s3.c == '0);
    s4_next.b_pos  = !s3.bh[BW-1] && (s3.bh != '0);
    s4_next.bmag   = (3*KB)'(s3.bh[BW-1] ? BW'(-s3.bh) : s3.bh);
    s4_next.cmag   = (3*KC)'(s3.c[CCW-1] ? CCW'(-s3.c) : s3.c);
  end

  // Stage 5: partial products of b^2/4 and a*|c|
  always_comb begin
    s5_next.org    = s4.org;
    s5_next.dir    = s4.dir;
    s5_next.a      = s4.a;
    s5_next.bh     = s4.bh;
    s5_next.c_neg  = s4.c_neg;
    s5_next.c_zero = s4.c_zero;
    s5_next.b_pos  = s4.b_pos;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s5_next.pb[i][j] = (2*KB)'(s4.bmag[KB*i +: KB] * s4.bmag[KB*j +: KB]);
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        s5_next.pac[i][j] = (KA+KC)'(s4.a[KA*i +: KA] * s4.cmag[KC*j +: KC]);
      end
    end
  end

  // Stage 6: row sums
  always_comb begin
    s6_next.org    = s5.org;
    s6_next.dir    = s5.dir;
    s6_next.a      = s5.a;
    s6_next.bh     = s5.bh;
    s6_next.c_neg  = s5.c_neg;
    s6_next.c_zero = s5.c_zero;
    s6_next.b_pos  = s5.b_pos;
    for (int i = 0; i < 3; i++) begin
      s6_next.rb[i] = (4*KB)'(s5.pb[i][0]) + ((4*KB)'(s5.pb[i][1]) << KB)
                    + ((4*KB)'(s5.pb[i][2]) << (2*KB));
    end
    for (int i = 0; i < 2; i++) begin
      s6_next.rac[i] = (KA+3*KC)'(s5.pac[i][0]) + ((KA+3*KC)'(s5.pac[i][1]) << KC)
                     + ((KA+3*KC)'(s5.pac[i][2]) << (2*KC));
    end
  end

  // Stage 7: full products
  always_comb begin
    s7_next.org    = s6.org;
    s7_next.dir    = s6.dir;
    s7_next.a      = s6.a;
    s7_next.bh     = s6.bh;
    s7_next.c_neg  = s6.c_neg;
    s7_next.c_zero = s6.c_zero;
    s7_next.b_pos  = s6.b_pos;
    s7_next.bb     = DW'(s6.rb[0]) + (DW'(s6.rb[1]) << KB) + (DW'(s6.rb[2]) << (2*KB));
    s7_next.ac     = ACW'(s6.rac[0]) + (ACW'(s6.rac[1]) << KA);
  end

  // Stage 8: quarter discriminant and classification
  always_comb begin
    dsum = s7.c_neg ? (DW+1)'(s7.bb) + (DW+1)'(s7.ac)
                    : (DW+1)'(s7.bb) - (DW+1)'(s7.ac);
    s8_next.org     = s7.org;
    s8_next.dir     = s7.dir;
    s8_next.a       = s7.a;
    s8_next.bh      = s7.bh;
    s8_next.disc    = dsum[DW-1:0];
    // near root when c >= 0 and b <= 0; far root otherwise
    s8_next.use_low = !s7.c_neg && !s7.b_pos;
    // zero direction, negative discriminant, or both roots behind the origin
    s8_next.miss    = (s7.a == '0) || dsum[DW]
                   || (s7.b_pos && !s7.c_neg && !s7.c_zero);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
      s7 <= s7_next;
      s8 <= s8_next;
    end
  end

endmodule

// ===== design/rsi_link_queue.sv =====
`timescale 1ns / 1ps
// rsi_link_queue: four-entry queue of classified items between the front
// and the back. Uses rsi_pkg.
module rsi_link_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  rsi_pkg::link_t  wdata,
  output logic            full,
  input  logic            rd,
  output rsi_pkg::link_t  rdata,
  output logic            empty
);
  import rsi_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTRW  = $clog2(DEPTH);

  link_t           mem [DEPTH];
  logic [PTRW-1:0] wp;
  logic [PTRW-1:0] rp;
  logic [PTRW:0]   cnt;

  assign full  = (cnt == (PTRW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (PTRW+1)'(wr) - (PTRW+1)'(rd);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

// ===== design/rsi_back.sv =====
`timescale 1ns / 1ps
// rsi_back: bit-per-stage square root and divider, hit point products,
// saturation and a two-entry result queue. Uses rsi_pkg.
module rsi_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             lq_empty,
  output logic             lq_pop,
  input  rsi_pkg::link_t   lq_data,
  output logic             empty,
  input  logic             pop,
  output rsi_pkg::result_t result
);
  import rsi_pkg::*;

  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTRW  = $clog2(OQ_DEPTH);
  localparam int PTW      = CW + KT + 1;

  typedef struct packed {
    vec3_t          org;
    vec3_t          dir;
    logic [AW-1:0]  a;
    logic [BW-1:0]  bh;
    logic           miss;
    logic           use_low;
    logic [XW-1:0]  x;
    logic [SW+1:0]  rem;
    logic [SW-1:0]  root;
  } sq_t;

  typedef struct packed {
    vec3_t          org;
    vec3_t          dir;
    logic [AW-1:0]  a;
    logic           miss;
    logic [QW-1:0]  n;
    logic [QW-1:0]  q;
    logic [AW-1:0]  rem;
  } dv_t;

  typedef struct packed {
    vec3_t                    org;
    logic                     miss;
    logic [RW-1:0]            dlen;
    logic [2:0][2:0][PTW-1:0] pt;
  } mu_t;

  typedef struct packed {
    vec3_t               org;
    logic                miss;
    logic [RW-1:0]       dlen;
    logic [2:0][PW-1:0]  prod;
  } sm_t;

  sq_t  sq   [SW+1];
  logic sq_v [SW+1];
  dv_t  dv   [QW+1];
  logic dv_v [QW+1];
  dv_t  dv_first;
  mu_t  mu, mu_next;
  sm_t  sm, sm_next;
  logic mu_v, sm_v;
  logic adv;

  logic [NW:0]        bsh, num;
  logic [3*KT-1:0]    tpad;
  logic [2:0][CW-1:0] pnt;
  logic [PW-1:0]      sh;
  logic [PW:0]        tot;
  logic [PW-CW+1:0]   hi_bits;
  result_t            res_next;

  result_t            oq [OQ_DEPTH];
  logic [OQ_PTRW-1:0] owp, orp;
  logic [OQ_PTRW:0]   ocnt;
  logic               oq_full, oq_wr, oq_rd;

  // The back holds as a whole only when its result queue is full
  assign oq_full = (ocnt == (OQ_PTRW+1)'(OQ_DEPTH));
  assign adv     = !(sm_v && oq_full);
  assign lq_pop  = adv && !lq_empty;

  // Square root entry, straight from the link queue head
  always_comb begin
    sq[0].org     = lq_data.org;
    sq[0].dir     = lq_data.dir;
    sq[0].a       = lq_data.a;
    sq[0].bh      = lq_data.bh;
    sq[0].miss    = lq_data.miss;
    sq[0].use_low = lq_data.use_low;
    sq[0].x       = {lq_data.disc, {(2*FB+2){1'b0}}};
    sq[0].rem     = '0;
    sq[0].root    = '0;
    sq_v[0]       = !lq_empty;
  end

  // Square root: one result bit per stage, two operand bits consumed
  for (genvar k = 0; k < SW; k++) begin : g_sq
    localparam int I = SW - 1 - k;
    logic [SW+3:0] wide, trial;
    sq_t           nx;
    always_comb begin
      wide  = {sq[k].rem, sq[k].x[2*I +: 2]};
      trial = {2'b00, sq[k].root, 2'b01};
      nx    = sq[k];
      if (wide >= trial) begin
        nx.rem  = (SW+2)'(wide - trial);
        nx.root = {sq[k].root[SW-2:0], 1'b1};
      end else begin
        nx.rem  = wide[SW+1:0];
        nx.root = {sq[k].root[SW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) sq[k+1] <= nx;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
  end

  // Numerator: -b*2^FB -/+ root; the near root rounds the root up
  always_comb begin
    bsh = (NW+1)'($signed(sq[SW].bh)) << (FB + 1);
    if (sq[SW].use_low) begin
      num = '0 - bsh - (NW+1)'(sq[SW].root) - (NW+1)'(sq[SW].rem != '0);
    end else begin
      num = (NW+1)'(sq[SW].root) - bsh;
    end
    dv_first.org  = sq[SW].org;
    dv_first.dir  = sq[SW].dir;
    dv_first.a    = sq[SW].a;
    dv_first.miss = sq[SW].miss;
    dv_first.n    = num[NW-1:1];
    dv_first.q    = '0;
    dv_first.rem  = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) dv[0] <= dv_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SW];
    end
  end

  // Restoring divider: t = floor((num/2) / a), one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_dv
    localparam int I = QW - 1 - k;
    logic [AW:0] wide;
    dv_t         nx;
    always_comb begin
      wide = {dv[k].rem, dv[k].n[I]};
      nx   = dv[k];
      if (wide >= {1'b0, dv[k].a}) begin
        nx.rem  = AW'(wide - {1'b0, dv[k].a});
        nx.q[I] = 1'b1;
      end else begin
        nx.rem  = wide[AW-1:0];
        nx.q[I] = 1'b0;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dv[k+1] <= nx;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end
  end

  // dir * t partial products, distance saturation
  always_comb begin
    tpad         = (3*KT)'(dv[QW].q);
    mu_next.org  = dv[QW].org;
    mu_next.miss = dv[QW].miss;
    mu_next.dlen = (dv[QW].q[QW-1:RW] != '0) ? {RW{1'b1}} : dv[QW].q[RW-1:0];
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        mu_next.pt[k][j] = PTW'($signed(dv[QW].dir[k])
                                * $signed({1'b0, tpad[KT*j +: KT]}));
      end
    end
  end

  // Partial product sums
  always_comb begin
    sm_next.org  = mu.org;
    sm_next.miss = mu.miss;
    sm_next.dlen = mu.dlen;
    for (int k = 0; k < 3; k++) begin
      sm_next.prod[k] = PW'($signed(mu.pt[k][0]))
                      + (PW'($signed(mu.pt[k][1])) << KT)
                      + (PW'($signed(mu.pt[k][2])) << (2*KT));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu <= mu_next;
      sm <= sm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_v <= 1'b0;
      sm_v <= 1'b0;
    end else if (adv) begin
      mu_v <= dv_v[QW];
      sm_v <= mu_v;
    end
  end

  // Hit point: origin + floor(dir * t / 2^FB), saturated
  always_comb begin
    pnt     = '0;
    sh      = '0;
    tot     = '0;
    hi_bits = '0;
    for (int k = 0; k < 3; k++) begin
      sh      = $signed(sm.prod[k]) >>> FB;
      tot     = (PW+1)'($signed(sh)) + (PW+1)'($signed(sm.org[k]));
      hi_bits = tot[PW:CW-1];
      if ((&hi_bits) || !(|hi_bits)) begin
        pnt[k] = tot[CW-1:0];
      end else if (tot[PW]) begin
        pnt[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pnt[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    if (sm.miss) begin
      res_next = '0;
    end else begin
      res_next.hit      = 1'b1;
      res_next.distance = sm.dlen;
      res_next.point_x  = pnt[0];
      res_next.point_y  = pnt[1];
      res_next.point_z  = pnt[2];
    end
  end

  // Result queue
  assign oq_wr  = sm_v && !oq_full;
  assign oq_rd  = pop && !empty;
  assign empty  = (ocnt == '0);
  assign result = oq[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (oq_wr) owp <= owp + 1'b1;
      if (oq_rd) orp <= orp + 1'b1;
      ocnt <= ocnt + (OQ_PTRW+1)'(oq_wr) - (OQ_PTRW+1)'(oq_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq[owp] <= res_next;
    end
  end

endmodule

// ===== design/ray_sphere_intersection_unit.sv =====
`timescale 1ns / 1ps
// Ray/sphere intersection unit top level: front pipeline, link queue and
// back pipeline. Uses rsi_pkg, rsi_front, rsi_link_queue, rsi_back.
//
// Takes one ray/sphere pair per clock while full is low and returns one
// result per pair, in order, at a sustained rate of one beat per cycle
// while results are popped. A pair passes from push to the output through
// the 8 front stages (coefficients, exact wide products, discriminant and
// classification), the first loading on the accepting edge, then the
// four-entry link queue, 83 square root stages, a numerator register and
// 83 divider stages, each stage producing one bit of the scaled root or of
// the distance, then registers for the hit point products and their sums,
// and the saturating add into a two-entry result queue. Front and back
// stall independently; full rises only when the front's last stage is
// held by a full link queue. All arithmetic is exact integer arithmetic,
// so results match the rsi_checker model bit for bit.
module ray_sphere_intersection_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  rsi_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output rsi_pkg::result_t result
);
  import rsi_pkg::*;

  link_t lq_wdata, lq_rdata;
  logic  lq_wr, lq_full, lq_rd, lq_empty;

  rsi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .lq_push (lq_wr),
    .lq_full (lq_full),
    .lq_data (lq_wdata)
  );

  rsi_link_queue u_link (
    .clk   (clk),
    .rst   (rst),
    .wr    (lq_wr),
    .wdata (lq_wdata),
    .full  (lq_full),
    .rd    (lq_rd),
    .rdata (lq_rdata),
    .empty (lq_empty)
  );

  rsi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .lq_empty (lq_empty),
    .lq_pop   (lq_rd),
    .lq_data  (lq_rdata),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== design/rsi_checker.sv =====
`timescale 1ns / 1ps
// rsi_port_props: port-level assertions for the ray/sphere unit, bound to
// the top level. Uses rsi_pkg and the unit's assertion macros.
`include "ray_sphere_intersection_unit_macros.svh"

module rsi_port_props (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input rsi_pkg::item_t   item,
  input logic             empty,
  input logic             pop,
  input rsi_pkg::result_t result
);
  import rsi_pkg::*;

  // A miss beat carries all-zero distance and point
  `RSI_ASSERT_IMP(a_miss_zero, !empty && !result.hit, result.distance == 0 && result.point_x == 0 && result.point_y == 0 && result.point_z == 0)

  // An untaken result beat stays put
  `RSI_ASSERT_NXT(a_result_hold, !empty && !pop, !empty && $stable(result))

  // In the cycle after a reset edge, nothing is waiting and input is open
  `RSI_ASSERT_RAW(a_reset_idle, rst, ##1 (empty && !full))

endmodule

bind ray_sphere_intersection_unit rsi_port_props u_rsi_port_props (.*);

// ===== dv/rsi_checker.sv =====
`timescale 1ns / 1ps
// rsi_checker: watches both queue channels of the ray/sphere unit, works out
// the exact intersection for each accepted ray and compares every result beat.
// Depends on rsi_pkg.
module rsi_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  rsi_pkg::item_t   item,
  input  logic             empty,
  input  logic             pop,
  input  rsi_pkg::result_t result,
  output int               errors,
  output int               outstanding,
  output int               hits_seen
);
  import rsi_pkg::*;

  typedef logic signed [319:0] wide_t;
  localparam wide_t POS_MAX = (wide_t'(1) <<< 31) - 1;
  localparam wide_t NEG_MIN = -(wide_t'(1) <<< 31);

  result_t expected_q[$];

  // Clamp to the signed 32-bit coordinate range
  function automatic logic [31:0] clamp32(wide_t v);
    if (v > POS_MAX) return 32'h7fff_ffff;
    if (v < NEG_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Exact ray/sphere intersection for one ray
  function automatic result_t ray_hit(item_t it);
    wide_t o[3], d[3], cen[3];
    wide_t lv, a, b, c, r2, disc, d4, num, den, t, q, rem, prod;
    logic [319:0] root, x, rbit, trial;
    logic use_low;
    logic [31:0] pt[3];
    result_t res;
    res = '0;
    o[0] = it.origin_x; o[1] = it.origin_y; o[2] = it.origin_z;
    d[0] = it.dir_x;    d[1] = it.dir_y;    d[2] = it.dir_z;
    cen[0] = it.center_x; cen[1] = it.center_y; cen[2] = it.center_z;
    a = 0; b = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      lv = o[i] - cen[i];
      a += d[i] * d[i];
      b += d[i] * lv;
      c += lv * lv;
    end
    b = b <<< 1;
    r2 = {289'b0, it.sphere_radius};
    c -= r2 * r2;
    disc = b * b - ((a * c) <<< 2);
    if (a == 0 || disc < 0) return res;
    use_low = (c >= 0) && (b <= 0);
    // origin outside with the sphere behind: both roots negative
    if (!use_low && c > 0) return res;

    // floor square root of the scaled discriminant
    d4 = disc <<< (2 * FB);
    x = d4;
    root = '0;
    rbit = 320'b1 << 318;
    while (rbit != 0 && rbit > x) rbit = rbit >> 2;
    while (rbit != 0) begin
      trial = root + rbit;
      if (x >= trial) begin
        x = x - trial;
        root = (root >> 1) + rbit;
      end else begin
        root = root >> 1;
      end
      rbit = rbit >> 2;
    end

    num = -(b <<< FB);
    if (use_low) begin
      if (root * root != d4) root = root + 1;
      num = num - wide_t'(root);
    end else begin
      num = num + wide_t'(root);
    end
    den = a <<< 1;
    // floored division
    if (num < 0) begin
      q = (-num) / den;
      rem = (-num) % den;
      if (rem != 0) q = q + 1;
      t = -q;
    end else begin
      t = num / den;
    end

    for (int i = 0; i < 3; i++) begin
      prod = (d[i] * t) >>> FB;
      pt[i] = clamp32(prod + o[i]);
    end
    res.hit = 1'b1;
    res.distance = RW'(clamp32(t));
    res.point_x = pt[0];
    res.point_y = pt[1];
    res.point_z = pt[2];
    return res;
  endfunction

  task automatic report(string fld, logic [31:0] exp_v, logic [31:0] got_v);
    $display("MISMATCH %s: expected %h got %h at %0t", fld, exp_v, got_v, $time);
    errors++;
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    hits_seen = 0;
  end

  // Sample at the falling edge: inputs and outputs are stable until the next rise
  always @(negedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (push && !full) expected_q.push_back(ray_hit(item));
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", 32'd0, 32'(result.hit));
        end else begin
          exp_r = expected_q.pop_front();
          if (result.hit) hits_seen++;
          if (result.hit !== exp_r.hit) report("hit", 32'(exp_r.hit), 32'(result.hit));
          if (result.distance !== exp_r.distance)
            report("distance", 32'(exp_r.distance), 32'(result.distance));
          if (result.point_x !== exp_r.point_x)
            report("point_x", exp_r.point_x, result.point_x);
          if (result.point_y !== exp_r.point_y)
            report("point_y", exp_r.point_y, result.point_y);
          if (result.point_z !== exp_r.point_z)
            report("point_z", exp_r.point_z, result.point_z);
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: clock, reset and ray stimulus for the ray/sphere unit, with idling
// phases and back-pressure; verdict from rsi_checker. Depends on rsi_pkg.
module tb_top;
  import rsi_pkg::*;

  localparam int ONE = 65536;
  localparam int LIMIT = 600000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  logic    full, empty;
  item_t   item = '0;
  result_t result;

  int errors, outstanding, hits_seen;
  int cycles = 0;
  int sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic held = 1'b0;
  int hold_cnt = 0;

  ray_sphere_intersection_unit u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  rsi_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .errors(errors), .outstanding(outstanding), .hits_seen(hits_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      pop <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !held) begin
      pop <= 1'b0;
      held <= 1'b1;
      hold_cnt <= 1500;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic item_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                               int cx, int cy, int cz, int r);
    item_t it;
    it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
    it.dir_x = dx;    it.dir_y = dy;    it.dir_z = dz;
    it.center_x = cx; it.center_y = cy; it.center_z = cz;
    it.sphere_radius = RW'(r);
    return it;
  endfunction

  // Mostly aimed rays at a random scale, the rest raw bit patterns
  function automatic item_t rand_ray();
    item_t it;
    int sh, nsh;
    logic signed [31:0] o[3], c[3], d[3];
    logic [319:0] raw;
    if ($urandom_range(99) < 25) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(item_t)-1:0];
      return it;
    end
    sh = $urandom_range(14, 1);
    nsh = $urandom_range(31, sh);
    for (int i = 0; i < 3; i++) begin
      c[i] = $signed($urandom) >>> sh;
      o[i] = $signed($urandom) >>> sh;
      d[i] = (c[i] - o[i]) + ($signed($urandom) >>> nsh);
      if ($urandom_range(3) == 0) d[i] = -d[i];
      if ($urandom_range(7) == 0) d[i] = $signed($urandom) >>> $urandom_range(31);
    end
    it = mk(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2],
            int'($urandom >> (sh + $urandom_range(2))));
    if ($urandom_range(9) == 0) it.sphere_radius = RW'($urandom);
    if ($urandom_range(19) == 0) it.origin_x = it.center_x;
    return it;
  endfunction

  // Offer one beat; full is stable between the falling and rising edges
  task automatic send(item_t x);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= x;
    do begin
      @(negedge clk);
      took = !full;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send(rand_ray());
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rays
    send(mk(0, 0, 0, 0, 0, 0, 5*ONE, 0, 0, ONE));             // zero direction
    send(mk(0, 0, 0, ONE, 0, 0, 5*ONE, 0, 0, ONE));           // plain hit
    send(mk(5*ONE, 0, 0, ONE, 0, 0, 5*ONE, 0, 0, 2*ONE));     // origin inside
    send(mk(4*ONE, 0, 0, ONE, 0, 0, 5*ONE, 0, 0, ONE));       // on the surface
    send(mk(0, ONE, 0, ONE, 0, 0, 5*ONE, 0, 0, ONE));         // tangent
    send(mk(0, 0, 0, -ONE, 0, 0, 5*ONE, 0, 0, ONE));          // sphere behind
    send(mk(0, 3*ONE, 0, ONE, 0, 0, 5*ONE, 0, 0, ONE));       // clean miss
    send(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0));
    send(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0, 32'h7fffffff));      // huge sphere
    send(mk(0, 0, 0, 3, 4, 0, 7*ONE, 9*ONE, 0, 3*ONE));       // tiny direction
    send(mk(32'h80000000, 0, 0, 1, 0, 0, 32'h7fff0000, 0, 0, ONE)); // far, saturating
    send(mk(5*ONE, 5*ONE, 5*ONE, -ONE, -ONE, -ONE, 0, 0, 0, ONE));
    send(mk(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 1,
            0, 0, 0, 32'h7fffffff));
    send(mk(-3*ONE, 0, 0, 32'h40000000, 0, 0, 3*ONE, 0, 0, ONE));
    send(mk(0, 0, 0, 0, 0, -ONE, 0, 0, -ONE/2, ONE));         // origin inside, -z
    send(mk(1, -1, 1, -7, 3, -5, -700, 300, -500, 9));
    drain();

    // No idling
    idle_pct = 0;  stall_pct = 0;  send_random(250);
    // Sender idle most of the time, then pause until everything is back
    idle_pct = 82; stall_pct = 0;  send_random(250);
    drain();
    // Receiver stalling most of the time
    idle_pct = 0;  stall_pct = 82; send_random(250);
    // Both idle now and then
    idle_pct = 26; stall_pct = 26; send_random(250);
    // Long receiver hold-off while rays keep coming: the unit must fill up
    idle_pct = 0;  stall_pct = 0;  hold_req <= 1'b1;
    send_random(250);

    drain();
    repeat (400) @(posedge clk);
    $display("Sent %0d rays (%0d hits returned) across directed, free-running,",
             sent, hits_seen);
    $display("idle, stall and long hold-off phases.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== ray_sphere_intersection_unit.f =====
+incdir+design
design/rsi_pkg.sv
design/rsi_front.sv
design/rsi_link_queue.sv
design/rsi_back.sv
design/ray_sphere_intersection_unit.sv
design/rsi_checker.sv
dv/rsi_checker.sv
dv/tb_top.sv
